// ===== rtl/core/tve_pkg.sv =====
// ============================================================================
// tve_pkg: shared types and constants of the tag/value field extractor
// Holds the character codes, result kinds, register indexes, the
// configuration and result structs, and the case-folding function.
// ============================================================================
package tve_pkg;

   // Number of tag characters held in the configuration registers.
   localparam int unsigned TAG_STORE = 19;
   localparam int unsigned TAG_BITS  = TAG_STORE * 8;

   // Characters that steer the parser.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] FOLD_LOW   = 8'h61;
   localparam logic [7:0] FOLD_HIGH  = 8'h7F;
   localparam logic [7:0] FOLD_DELTA = 8'h20;

   // Kinds of result beat.
   localparam logic [1:0] KIND_BYTE      = 2'd0;
   localparam logic [1:0] KIND_FOUND     = 2'd1;
   localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

   // Register map: register i sits at byte address 8*i.
   localparam int unsigned CSR_ADDR_W = 6;
   localparam logic [2:0] REG_TAG_LOW    = 3'd0;
   localparam logic [2:0] REG_TAG_MID    = 3'd1;
   localparam logic [2:0] REG_TAG_HIGH   = 3'd2;
   localparam logic [2:0] REG_TAG_LENGTH = 3'd3;
   localparam logic [2:0] REG_VAL_LIMIT  = 3'd4;

   localparam logic [7:0] VALUE_LIMIT_RESET = 8'd29;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag_chars;   // character 0 in the low byte
      logic [4:0]          tag_length;
      logic [7:0]          value_limit;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] value_byte;
   } result_type;

   // Upper-case fold used on both sides of the key compare.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= FOLD_LOW && c <= FOLD_HIGH) begin
         r = c - FOLD_DELTA;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/tve_csr.sv =====
// ============================================================================
// tve_csr: configuration registers
// APB-style register file holding the tag characters, tag length and
// value limit, with read-back of every register.
// ============================================================================
module tve_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tve_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [63:0]                         csr_pwdata,
   output logic [63:0]                         csr_prdata,
   output logic                                csr_pready,
   output tve_pkg::cfg_type                    cfg
);

   logic [63:0] tag_low_ff;
   logic [63:0] tag_mid_ff;
   logic [23:0] tag_high_ff;
   logic [4:0]  tag_length_ff;
   logic [7:0]  value_limit_ff;
   logic [2:0]  reg_index;
   logic        write_en;

   assign reg_index  = csr_paddr[tve_pkg::CSR_ADDR_W-1:3];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_low_ff     <= '0;
         tag_mid_ff     <= '0;
         tag_high_ff    <= '0;
         tag_length_ff  <= '0;
         value_limit_ff <= tve_pkg::VALUE_LIMIT_RESET;
      end else if (write_en) begin
         case (reg_index)
            tve_pkg::REG_TAG_LOW:    tag_low_ff     <= csr_pwdata;
            tve_pkg::REG_TAG_MID:    tag_mid_ff     <= csr_pwdata;
            tve_pkg::REG_TAG_HIGH:   tag_high_ff    <= csr_pwdata[23:0];
            tve_pkg::REG_TAG_LENGTH: tag_length_ff  <= csr_pwdata[4:0];
            tve_pkg::REG_VAL_LIMIT:  value_limit_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         tve_pkg::REG_TAG_LOW:    csr_prdata = tag_low_ff;
         tve_pkg::REG_TAG_MID:    csr_prdata = tag_mid_ff;
         tve_pkg::REG_TAG_HIGH:   csr_prdata = {40'd0, tag_high_ff};
         tve_pkg::REG_TAG_LENGTH: csr_prdata = {59'd0, tag_length_ff};
         tve_pkg::REG_VAL_LIMIT:  csr_prdata = {56'd0, value_limit_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   assign cfg.tag_chars   = {tag_high_ff, tag_mid_ff, tag_low_ff};
   assign cfg.tag_length  = tag_length_ff;
   assign cfg.value_limit = value_limit_ff;

endmodule

// ===== rtl/core/tve_parser.sv =====
// ============================================================================
// tve_parser: key/value parse state machine
// Holds the parse mode, key length, match flag and value count, and forms
// the result of each accepted byte in a single pass.
// ============================================================================
module tve_parser #(
   parameter int unsigned MAX_TAG_LEN = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tve_pkg::cfg_type     cfg,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   output tve_pkg::result_type  result
);

   localparam int unsigned KW = $clog2(MAX_TAG_LEN + 1);

   typedef enum logic [1:0] {
      MODE_KEY,
      MODE_VALUE,
      MODE_SKIP,
      MODE_IDLE
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [KW-1:0]       key_length_ff, key_length_in;
   logic                key_matches_ff, key_matches_in;
   logic [7:0]          value_count_ff, value_count_in;
   logic [4:0]          key_pos;
   logic [7:0]          tag_char;
   tve_pkg::result_type res;

   assign key_pos = 5'(key_length_ff);

   // Tag character at the current key position; positions past storage are empty.
   always_comb begin
      tag_char = tve_pkg::CHAR_NUL;
      for (int i = 0; i < int'(tve_pkg::TAG_STORE); i++) begin
         if (key_pos == 5'(i)) begin
            tag_char = cfg.tag_chars[i*8 +: 8];
         end
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      key_length_in  = key_length_ff;
      key_matches_in = key_matches_ff;
      value_count_in = value_count_ff;
      res            = '0;
      case (mode_ff)
         MODE_KEY: begin
            if (data_byte == tve_pkg::CHAR_NUL) begin
               key_length_in  = '0;
               key_matches_in = 1'b1;
               value_count_in = '0;
               res.valid      = 1'b1;
               res.kind       = tve_pkg::KIND_NOT_FOUND;
            end else if (data_byte == tve_pkg::CHAR_SEMI) begin
               key_length_in  = '0;
               key_matches_in = 1'b1;
            end else if (data_byte == tve_pkg::CHAR_EQUAL) begin
               if (key_matches_ff && key_pos == cfg.tag_length) begin
                  mode_in        = MODE_VALUE;
                  value_count_in = '0;
               end else begin
                  mode_in = MODE_SKIP;
               end
            end else if (key_pos >= 5'(MAX_TAG_LEN)) begin
               key_matches_in = 1'b0;
            end else begin
               if (key_pos >= cfg.tag_length || tag_char == tve_pkg::CHAR_NUL ||
                   tve_pkg::fold_case(tag_char) != tve_pkg::fold_case(data_byte)) begin
                  key_matches_in = 1'b0;
               end
               key_length_in = key_length_ff + KW'(1);
            end
         end
         MODE_VALUE: begin
            if (data_byte == tve_pkg::CHAR_SEMI || data_byte < tve_pkg::CHAR_SPACE) begin
               if (data_byte == tve_pkg::CHAR_NUL) begin
                  mode_in        = MODE_KEY;
                  key_length_in  = '0;
                  key_matches_in = 1'b1;
                  value_count_in = '0;
               end else begin
                  mode_in = MODE_IDLE;
               end
               res.valid = 1'b1;
               res.kind  = tve_pkg::KIND_FOUND;
            end else if (value_count_ff < cfg.value_limit) begin
               value_count_in = value_count_ff + 8'd1;
               res.valid      = 1'b1;
               res.kind       = tve_pkg::KIND_BYTE;
               res.value_byte = data_byte;
            end
         end
         MODE_SKIP: begin
            if (data_byte == tve_pkg::CHAR_NUL) begin
               mode_in        = MODE_KEY;
               key_length_in  = '0;
               key_matches_in = 1'b1;
               value_count_in = '0;
               res.valid      = 1'b1;
               res.kind       = tve_pkg::KIND_NOT_FOUND;
            end else if (data_byte == tve_pkg::CHAR_SEMI) begin
               mode_in        = MODE_KEY;
               key_length_in  = '0;
               key_matches_in = 1'b1;
            end
         end
         default: begin
            if (data_byte == tve_pkg::CHAR_NUL) begin
               mode_in        = MODE_KEY;
               key_length_in  = '0;
               key_matches_in = 1'b1;
               value_count_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_KEY;
         key_length_ff  <= '0;
         key_matches_ff <= 1'b1;
         value_count_ff <= '0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         key_length_ff  <= key_length_in;
         key_matches_ff <= key_matches_in;
         value_count_ff <= value_count_in;
      end
   end

   assign result.valid      = res.valid && accept;
   assign result.kind       = res.kind;
   assign result.value_byte = res.value_byte;

endmodule

// ===== rtl/core/tve_rsp_queue.sv =====
// ============================================================================
// tve_rsp_queue: two-entry result buffer
// Registers result beats and holds a second one while the consumer stalls,
// so the parser can keep taking bytes.
// ============================================================================
module tve_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  tve_pkg::result_type push,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_result_kind,
   output logic [7:0]          rsp_value_byte
);

   logic [9:0] slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign do_push = push.valid;
   assign do_pop  = rsp_valid && !rsp_stall;
   assign full    = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= {push.kind, push.value_byte};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   assign rsp_result_kind = slot_ff[rd_ptr_ff][9:8];
   assign rsp_value_byte  = slot_ff[rd_ptr_ff][7:0];

endmodule

// ===== rtl/core/tag_value_field_extractor.sv =====
// ============================================================================
// tag_value_field_extractor: tag lookup in a key=value byte stream
// Scans "key=value;key=value" text one byte per beat, matches keys against
// a configured tag without regard to case, and emits the value's bytes
// followed by a found beat, or a not-found beat when the string ends.
// ============================================================================
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  req_data_byte[7:0]
//   rsp       out        rsp_valid/rsp_stall  rsp_result_kind[1:0], rsp_value_byte[7:0]
//   csr       in/out     APB, pready high     64-bit registers at byte address 8*i
//
// One byte beat is taken every clock cycle while the result buffer has room;
// a byte's result beat, if any, is registered in the result buffer and goes out on rsp from there.
// The rate is set by the parse state update, one pass of logic per byte.
// Results wait in a two-entry buffer: req_stall rises only when both entries
// are full, so one stalled result never blocks the next byte.
// Reset (synchronous, active high) empties the buffer, puts the parser at
// the start of a string and loads the register reset values.
//
module tag_value_field_extractor #(
   parameter int unsigned MAX_TAG_LEN = 19
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_result_kind,
   output logic [7:0]                     rsp_value_byte,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tve_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]                    csr_pwdata,
   output logic [63:0]                    csr_prdata,
   output logic                           csr_pready
);

   tve_pkg::cfg_type    cfg;
   tve_pkg::result_type result;
   logic                queue_full;
   logic                req_accept;

   // A byte is taken whenever the result buffer has room; every byte
   // makes at most one result beat, so one free entry is enough.
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   tve_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The parser updates its mode, key length, match flag and value count
   // on each accepted byte and forms that byte's result in the same pass.
   tve_parser #(
      .MAX_TAG_LEN (MAX_TAG_LEN)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .result    (result)
   );

   // The result buffer is the output register plus one skid entry.
   tve_rsp_queue u_rsp_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (result),
      .full            (queue_full),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_value_byte  (rsp_value_byte)
   );

endmodule

// ===== rtl/core/tve_checker.sv =====
// ============================================================================
// tve_checker: port-level checks of the field extractor
// Watches the request and result channels and flags illegal result beats
// and broken back-pressure behavior.
// ============================================================================
module tve_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_result_kind,
   input logic [7:0] rsp_value_byte
);

   // No result kind beyond not-found is ever produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == tve_pkg::KIND_BYTE ||
                     rsp_result_kind == tve_pkg::KIND_FOUND ||
                     rsp_result_kind == tve_pkg::KIND_NOT_FOUND))
      else $error("result beat with an unknown kind");

   // Found and not-found beats carry a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != tve_pkg::KIND_BYTE) |-> rsp_value_byte == 8'd0)
      else $error("status beat with a nonzero value byte");

   // The input side stalls only while results are backed up.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_result_kind) && $stable(rsp_value_byte)))
      else $error("stalled result beat changed");

endmodule

bind tag_value_field_extractor tve_checker u_tve_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_value_byte  (rsp_value_byte)
);

// ===== tb/tag_value_field_extractor_test.sv =====
// ============================================================================
// tag_value_field_extractor_test: self-checking bench for the tag extractor
// Streams key=value text into the block one byte beat at a time, predicts
// every value, found and not-found beat in a model kept inside the bench,
// and compares each result beat in order. Tags and limits are loaded over
// the APB port between phases, and both sides stall at random.
// ============================================================================
`timescale 1ns / 1ps

module tag_value_field_extractor_test;

   // The block is built with the default tag length limit.
   localparam int MAX_TAG_LEN = 19;
   // Idle cycles allowed after the last expected beat, given the registered
   // result path and a two-entry result buffer.
   localparam int DRAIN_CYCLES = 4;
   // Cycles with no beat on any port before the run is declared hung. Random
   // stalls of under one half never come close to this.
   localparam int QUIET_LIMIT = 1000;
   localparam int ITEMS_PER_SETTING = 110;
   localparam int SHOWN_FAULTS = 10;

   localparam logic [7:0] UPPER_A = "A";
   localparam logic [7:0] UPPER_Z = "Z";
   localparam logic [7:0] UPPER_LOW = tve_pkg::FOLD_LOW - tve_pkg::FOLD_DELTA;
   localparam logic [7:0] UPPER_HIGH = tve_pkg::FOLD_HIGH - tve_pkg::FOLD_DELTA;

   typedef enum logic [1:0] {
      SCAN_KEY,
      SCAN_VALUE,
      SCAN_SKIP,
      SCAN_IDLE
   } scan_mode_type;

   // Shapes of key that the random traffic produces.
   typedef enum int {
      KEY_TAG,
      KEY_NEAR,
      KEY_LONG,
      KEY_OTHER
   } key_style_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
   } result_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [7:0]                     req_data_byte = 8'h00;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [1:0]                     rsp_result_kind;
   logic [7:0]                     rsp_value_byte;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [tve_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [63:0]                    csr_pwdata = '0;
   logic [63:0]                    csr_prdata;
   logic                           csr_pready;

   // Bench copy of the configuration registers, at their reset values.
   logic [tve_pkg::TAG_BITS-1:0] tag_chars = '0;
   logic [4:0]                   tag_len = 5'd0;
   logic [7:0]                   value_limit = tve_pkg::VALUE_LIMIT_RESET;

   // Bench copy of the parser state.
   scan_mode_type scan_mode = SCAN_KEY;
   int            key_len = 0;
   bit            key_ok = 1'b1;
   int            value_count = 0;

   // Result beats predicted but not yet seen, oldest first.
   result_beat_type pending_beats[$];

   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int fault_count = 0;
   int scanned_items = 0;
   int quiet_cycles = 0;

   tag_value_field_extractor #(
      .MAX_TAG_LEN(MAX_TAG_LEN)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_value_byte (rsp_value_byte),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Keys compare in upper case: 0x61..0x7F fold down onto 0x41..0x5F.
   function automatic logic [7:0] upper_fold(input logic [7:0] c);
      if (c >= tve_pkg::FOLD_LOW && c <= tve_pkg::FOLD_HIGH) begin
         return c - tve_pkg::FOLD_DELTA;
      end
      return c;
   endfunction

   // Positions past the stored characters hold nothing, so a tag longer than
   // the store can never be matched.
   function automatic logic [7:0] tag_char_at(input int pos);
      if (pos < tve_pkg::TAG_STORE) begin
         return tag_chars[8*pos +: 8];
      end
      return tve_pkg::CHAR_NUL;
   endfunction

   function automatic void queue_beat(input logic [1:0] kind, input logic [7:0] value);
      result_beat_type beat;
      beat.kind = kind;
      beat.value = value;
      pending_beats.push_back(beat);
   endfunction

   function automatic void begin_string();
      scan_mode = SCAN_KEY;
      key_len = 0;
      key_ok = 1'b1;
      value_count = 0;
   endfunction

   // Advances the bench parser by one accepted byte and queues the result
   // beat that the byte causes, if any.
   function automatic void scan_byte(input logic [7:0] b);
      logic [7:0] t;
      case (scan_mode)
         SCAN_KEY: begin
            if (b == tve_pkg::CHAR_NUL) begin
               begin_string();
               queue_beat(tve_pkg::KIND_NOT_FOUND, 8'h00);
            end else if (b == tve_pkg::CHAR_SEMI) begin
               // Junk before any '=' is dropped and a fresh key begins.
               key_len = 0;
               key_ok = 1'b1;
            end else if (b == tve_pkg::CHAR_EQUAL) begin
               if (key_ok && key_len == int'(tag_len) && key_len <= MAX_TAG_LEN) begin
                  scan_mode = SCAN_VALUE;
                  value_count = 0;
               end else begin
                  scan_mode = SCAN_SKIP;
               end
            end else if (key_len >= MAX_TAG_LEN) begin
               // An overlong key stops counting and can no longer match.
               key_ok = 1'b0;
            end else begin
               t = tag_char_at(key_len);
               if (key_len >= int'(tag_len) || t == tve_pkg::CHAR_NUL ||
                   upper_fold(t) != upper_fold(b)) begin
                  key_ok = 1'b0;
               end
               key_len++;
            end
         end
         SCAN_VALUE: begin
            if (b == tve_pkg::CHAR_SEMI || b < tve_pkg::CHAR_SPACE) begin
               // A zero byte also ends the string, so the next one starts
               // at once instead of waiting in idle.
               if (b == tve_pkg::CHAR_NUL) begin
                  begin_string();
               end else begin
                  scan_mode = SCAN_IDLE;
               end
               queue_beat(tve_pkg::KIND_FOUND, 8'h00);
            end else if (value_count < int'(value_limit)) begin
               value_count++;
               queue_beat(tve_pkg::KIND_BYTE, b);
            end
         end
         SCAN_SKIP: begin
            if (b == tve_pkg::CHAR_NUL) begin
               begin_string();
               queue_beat(tve_pkg::KIND_NOT_FOUND, 8'h00);
            end else if (b == tve_pkg::CHAR_SEMI) begin
               scan_mode = SCAN_KEY;
               key_len = 0;
               key_ok = 1'b1;
            end
         end
         default: begin
            if (b == tve_pkg::CHAR_NUL) begin
               begin_string();
            end
         end
      endcase
   endfunction

   function automatic void load_register(input logic [2:0] idx, input logic [63:0] value);
      case (idx)
         tve_pkg::REG_TAG_LOW:    tag_chars[63:0] = value;
         tve_pkg::REG_TAG_MID:    tag_chars[127:64] = value;
         tve_pkg::REG_TAG_HIGH:   tag_chars[tve_pkg::TAG_BITS-1:128] = value[23:0];
         tve_pkg::REG_TAG_LENGTH: tag_len = value[4:0];
         tve_pkg::REG_VAL_LIMIT:  value_limit = value[7:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // The receiver stalls at random. The draw is made on every edge, so the
   // stall pattern slides across every phase of the parser's work.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Offers one byte beat, after a random gap, and holds it until the block
   // takes it. The prediction is made at the accepting edge, and every
   // accepted byte counts toward the traffic total.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      scanned_items++;
      scan_byte(b);
   endtask

   // Drops valid, waits for every predicted beat and then a few more cycles,
   // so that a byte with no result still in flight has cleared the block.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: a setup cycle, then an access cycle that completes on the
   // edge where pready is seen high. The trailing edge keeps back-to-back
   // writes from assigning psel twice in one time step.
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      load_register(idx, value);
      @(posedge clock);
   endtask

   task automatic program_search(input logic [tve_pkg::TAG_BITS-1:0] tag,
                                 input logic [4:0] len, input logic [7:0] limit);
      csr_write(tve_pkg::REG_TAG_LOW, tag[63:0]);
      csr_write(tve_pkg::REG_TAG_MID, tag[127:64]);
      csr_write(tve_pkg::REG_TAG_HIGH, {40'd0, tag[tve_pkg::TAG_BITS-1:128]});
      csr_write(tve_pkg::REG_TAG_LENGTH, {59'd0, len});
      csr_write(tve_pkg::REG_VAL_LIMIT, {56'd0, limit});
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_fault(input string what, input int wanted, input int seen);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS) begin
         $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
                  wanted, seen);
      end
   endtask

   // Each result beat is matched against the oldest prediction.
   always @(posedge clock) begin : check_beat
      result_beat_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            report_fault("unexpected result beat, kind", -1, int'(rsp_result_kind));
         end else begin
            wanted = pending_beats.pop_front();
            if (rsp_result_kind !== wanted.kind) begin
               report_fault("result_kind", int'(wanted.kind), int'(rsp_result_kind));
            end
            if (rsp_value_byte !== wanted.value) begin
               report_fault("value_byte", int'(wanted.value), int'(rsp_value_byte));
            end
         end
      end
   end

   // Any beat on either channel, or an APB access, counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Random traffic generation
   // ------------------------------------------------------------------------

   function automatic logic [7:0] random_key_char();
      logic [7:0] c;
      if ($urandom_range(3) != 0) begin
         c = 8'($urandom_range(UPPER_Z, UPPER_A));
         if ($urandom_range(1) == 1) begin
            c = c + tve_pkg::FOLD_DELTA;
         end
      end else begin
         do c = 8'($urandom_range(255, 1));
         while (c == tve_pkg::CHAR_SEMI || c == tve_pkg::CHAR_EQUAL);
      end
      return c;
   endfunction

   function automatic logic [7:0] random_value_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255, tve_pkg::CHAR_SPACE)); while (c == tve_pkg::CHAR_SEMI);
      return c;
   endfunction

   // Tags are mostly letters of either case, with the characters at the
   // edges of the fold range, arbitrary bytes from 0x21 up and the odd zero mixed in.
   function automatic logic [tve_pkg::TAG_BITS-1:0] random_tag();
      logic [tve_pkg::TAG_BITS-1:0] tag;
      int r;
      for (int i = 0; i < tve_pkg::TAG_STORE; i++) begin
         r = $urandom_range(99);
         if (r < 40) begin
            tag[8*i +: 8] = 8'($urandom_range(UPPER_Z, UPPER_A));
         end else if (r < 70) begin
            tag[8*i +: 8] = 8'($urandom_range(UPPER_Z, UPPER_A)) + tve_pkg::FOLD_DELTA;
         end else if (r < 78) begin
            if ($urandom_range(1) == 1) begin
               tag[8*i +: 8] = 8'($urandom_range(tve_pkg::FOLD_HIGH,
                                                 tve_pkg::FOLD_HIGH - 8'd4));
            end else begin
               tag[8*i +: 8] = 8'($urandom_range(UPPER_HIGH, UPPER_HIGH - 8'd4));
            end
         end else if (r < 97) begin
            tag[8*i +: 8] = 8'($urandom_range(255, 8'h21));
         end else begin
            tag[8*i +: 8] = tve_pkg::CHAR_NUL;
         end
      end
      return tag;
   endfunction

   // Sends a key built from the current tag. Tag characters that would end
   // the key are swapped for ordinary ones, and letters switch case at random.
   task automatic send_key(input key_style_type style);
      int fit;
      int count;
      int spoil;
      bit scramble;
      logic [7:0] c;
      fit = (int'(tag_len) > MAX_TAG_LEN) ? MAX_TAG_LEN : int'(tag_len);
      count = fit;
      spoil = -1;
      scramble = 1'b0;
      case (style)
         KEY_NEAR: begin
            case ($urandom_range(2))
               0: if (fit > 0) spoil = $urandom_range(fit - 1); else count = 1;
               1: count = fit + 1;
               default: count = (fit > 0) ? fit - 1 : 1;
            endcase
         end
         KEY_LONG:  count = $urandom_range(MAX_TAG_LEN + 4, MAX_TAG_LEN + 1);
         KEY_OTHER: begin
            count = $urandom_range(6);
            scramble = 1'b1;
         end
         default: ;
      endcase
      for (int i = 0; i < count; i++) begin
         if (scramble || i == spoil || i >= tve_pkg::TAG_STORE) begin
            c = random_key_char();
         end else begin
            c = tag_char_at(i);
            if (c == tve_pkg::CHAR_NUL || c == tve_pkg::CHAR_SEMI ||
                c == tve_pkg::CHAR_EQUAL) begin
               c = random_key_char();
            end
         end
         if ($urandom_range(1) == 1) begin
            if (c >= UPPER_LOW && c <= UPPER_HIGH) begin
               c = c + tve_pkg::FOLD_DELTA;
            end else if (c >= tve_pkg::FOLD_LOW && c <= tve_pkg::FOLD_HIGH) begin
               c = c - tve_pkg::FOLD_DELTA;
            end
         end
         send_byte(c);
      end
   endtask

   // Values are short as a rule. Now and then one runs past the limit so the
   // drop of surplus bytes is exercised.
   task automatic send_value();
      int count;
      if ($urandom_range(24) == 0) begin
         count = $urandom_range(value_limit + 8);
      end else begin
         count = $urandom_range(6);
      end
      repeat (count) send_byte(random_value_char());
   endtask

   // One string: a few fields, most of them well formed, then the zero byte.
   // The last value or key is sometimes left open so the zero byte ends it.
   task automatic send_random_string();
      int fields;
      int r;
      key_style_type style;
      fields = $urandom_range(4, 1);
      for (int f = 0; f < fields; f++) begin
         r = $urandom_range(99);
         if (r < 10) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255, 1)));
         end else if (r < 20) begin
            send_key(KEY_OTHER);
            send_byte(tve_pkg::CHAR_SEMI);
         end else begin
            style = (r < 55) ? KEY_TAG : (r < 75) ? KEY_NEAR : (r < 85) ? KEY_LONG : KEY_OTHER;
            send_key(style);
            if ($urandom_range(19) == 0) begin
               break;
            end
            send_byte(tve_pkg::CHAR_EQUAL);
            send_value();
            r = $urandom_range(9);
            if (f == fields - 1 && r < 3) begin
               break;
            end else if (r < 8) begin
               send_byte(tve_pkg::CHAR_SEMI);
            end else begin
               send_byte(8'($urandom_range(tve_pkg::CHAR_SPACE - 8'd1, 1)));
            end
         end
      end
      send_byte(tve_pkg::CHAR_NUL);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Out of reset the tag is empty, so a bare '=' opens a value at once.
   // The 0xFF value byte is then ended by the zero byte itself.
   task automatic test_empty_tag_at_reset();
      send_byte(tve_pkg::CHAR_EQUAL);
      send_byte(8'hFF);
      send_byte(tve_pkg::CHAR_NUL);
      settle();
   endtask

   // Tag "a" followed by DEL, one value byte allowed. The key arrives as "A"
   // and underscore, which fold to the same codes. The second value byte is
   // dropped, ';' reports found, and idle swallows the rest of the string.
   task automatic test_case_folding();
      csr_write(tve_pkg::REG_TAG_LOW, 64'h7F61);
      csr_write(tve_pkg::REG_TAG_LENGTH, 64'd2);
      csr_write(tve_pkg::REG_VAL_LIMIT, 64'd1);
      send_byte("A");
      send_byte(8'h5F);
      send_byte(tve_pkg::CHAR_EQUAL);
      send_byte("x");
      send_byte("y");
      send_byte(tve_pkg::CHAR_SEMI);
      send_byte("q");
      send_byte(tve_pkg::CHAR_NUL);
      settle();
   endtask

   // The string ends once in key mode after a junk field and once while
   // skipping a value whose key did not match.
   task automatic test_missing_tag();
      send_byte("k");
      send_byte(tve_pkg::CHAR_SEMI);
      send_byte(tve_pkg::CHAR_NUL);
      send_byte("b");
      send_byte(tve_pkg::CHAR_EQUAL);
      send_byte("c");
      send_byte(tve_pkg::CHAR_NUL);
      settle();
   endtask

   // With no value bytes allowed only the found beat comes out; here a
   // control byte ends the value, and the zero byte in idle is silent.
   task automatic test_zero_value_limit();
      csr_write(tve_pkg::REG_TAG_LENGTH, 64'd0);
      csr_write(tve_pkg::REG_VAL_LIMIT, 64'd0);
      send_byte(tve_pkg::CHAR_EQUAL);
      send_byte("z");
      send_byte(8'h1F);
      send_byte(tve_pkg::CHAR_NUL);
      settle();
   endtask

   // A zero tag character matches no key byte at all.
   task automatic test_zero_tag_character();
      csr_write(tve_pkg::REG_TAG_LOW, 64'd0);
      csr_write(tve_pkg::REG_TAG_LENGTH, 64'd1);
      csr_write(tve_pkg::REG_VAL_LIMIT, {56'd0, tve_pkg::VALUE_LIMIT_RESET});
      send_byte("A");
      send_byte(tve_pkg::CHAR_EQUAL);
      send_byte("v");
      send_byte(tve_pkg::CHAR_NUL);
      settle();
   endtask

   // One idling pattern across four settings: empty tag with no value
   // bytes, a full-length tag with the widest limit, a tag longer than the
   // store, and a random tag with a small limit.
   task automatic test_random_traffic(input int gap_pct, input int stall_pct);
      logic [4:0] len;
      logic [7:0] limit;
      int goal;
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < 4; k++) begin
         case (k)
            0: begin
               len = 5'd0;
               limit = 8'd0;
            end
            1: begin
               len = 5'(MAX_TAG_LEN);
               limit = 8'd255;
            end
            2: begin
               len = 5'($urandom_range(31, MAX_TAG_LEN + 1));
               limit = 8'd1;
            end
            default: begin
               len = 5'($urandom_range(MAX_TAG_LEN - 1, 1));
               limit = 8'($urandom_range(12, 2));
            end
         endcase
         program_search(random_tag(), len, limit);
         goal = scanned_items + ITEMS_PER_SETTING;
         while (scanned_items < goal) send_random_string();
         settle();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      req_gap_pct = 6;
      rsp_stall_pct = 48;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_tag_at_reset();
      test_case_folding();
      test_missing_tag();
      test_zero_value_limit();
      test_zero_tag_character();

      // Sender mostly busy with a stalling receiver, then the reverse, then
      // full rate on both sides.
      test_random_traffic(6, 48);
      test_random_traffic(48, 6);
      test_random_traffic(0, 0);

      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/tve_pkg.sv
rtl/core/tve_csr.sv
rtl/core/tve_parser.sv
rtl/core/tve_rsp_queue.sv
rtl/core/tag_value_field_extractor.sv
rtl/core/tve_checker.sv
tb/tag_value_field_extractor_test.sv
